### hw/rtl/polled_interrupt_timer_table_core_assert.svh
// Assertion macros for the polled interrupt timer table checker.
`ifndef POLLED_INTERRUPT_TIMER_TABLE_CORE_ASSERT_SVH
`define POLLED_INTERRUPT_TIMER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PITT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pitt assertion failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define PITT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pitt assertion failed");

`endif

### hw/rtl/pitt_pkg.sv
// Shared types and constants of the polled interrupt timer table.
`timescale 1ns / 1ps

package pitt_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;

  localparam int OP_W       = 2;
  localparam int LINE_W     = 16;
  localparam int IVL_W      = 16;
  localparam int PERIOD_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int CNT_OUT_W  = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd50;

  typedef enum logic [OP_W-1:0] {
    OP_ADD,
    OP_DELETE,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE,
    ST_FULL,
    ST_NOT_FOUND,
    ST_FIRED,
    ST_NONE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_PERIOD,
    REG_RELOAD_MODE
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADD,
    S_DEL_SCAN,
    S_DEL_MOVE,
    S_TICK_SCAN,
    S_TICK_END,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_IDX,
    RD_NEXT,
    RD_TAIL
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ADD,
    WR_MOVE,
    WR_TICK
  } wr_sel_t;

  typedef enum logic [1:0] {
    EM_NONE,
    EM_PEND,
    EM_CODE
  } emit_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    start;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    idx_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    pend_load;
    emit_t   emit;
    logic    emit_last;
    status_t code;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic scan_last;
    logic match;
    logic fire;
    logic pend_valid;
    logic out_free;
    logic disabled;
  } stat_t;

endpackage

### hw/rtl/pitt_ifs.sv
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface pitt_item_if;
  logic                        valid;
  logic                        ready;
  logic [pitt_pkg::OP_W-1:0]   operation;
  logic [pitt_pkg::LINE_W-1:0] irq_line;
  logic [pitt_pkg::IVL_W-1:0]  interval;

  modport source (output valid, operation, irq_line, interval, input ready);
  modport sink   (input valid, operation, irq_line, interval, output ready);
endinterface

interface pitt_result_if;
  logic                           valid;
  logic                           ready;
  logic [pitt_pkg::LINE_W-1:0]    fired_line;
  logic [pitt_pkg::STATUS_W-1:0]  status;
  logic [pitt_pkg::CNT_OUT_W-1:0] fill_level;
  logic                           last;

  modport source (output valid, fired_line, status, fill_level, last, input ready);
  modport sink   (input valid, fired_line, status, fill_level, last, output ready);
endinterface

interface pitt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pitt_pkg::CFG_IDX_W-1:0]  index;
  logic [pitt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/pitt_ctrl.sv
// Sequencing state machine of the polled interrupt timer table.
`timescale 1ns / 1ps

module pitt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pitt_pkg::stat_t stat,
  output pitt_pkg::cmd_t  cmd
);

  pitt_pkg::state_t state;
  pitt_pkg::state_t state_next;
  logic             advance;

  // tick scan stalls only when a second firing must push out the held one while the result register is busy
  assign advance = !(stat.fire && stat.pend_valid && !stat.out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pitt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pitt_pkg::S_IDLE: begin
        if (in_valid) state_next = pitt_pkg::S_DECODE;
      end
      pitt_pkg::S_DECODE: begin
        case (stat.op)
          pitt_pkg::OP_ADD: state_next = pitt_pkg::S_ADD;
          pitt_pkg::OP_DELETE: begin
            state_next = stat.empty ? pitt_pkg::S_FINISH : pitt_pkg::S_DEL_SCAN;
          end
          pitt_pkg::OP_TICK: begin
            state_next = (stat.empty || stat.disabled) ? pitt_pkg::S_FINISH
                                                       : pitt_pkg::S_TICK_SCAN;
          end
          default: state_next = pitt_pkg::S_FINISH;
        endcase
      end
      pitt_pkg::S_ADD: begin
        if (stat.out_free) state_next = pitt_pkg::S_IDLE;
      end
      pitt_pkg::S_DEL_SCAN: begin
        if (stat.match) state_next = pitt_pkg::S_DEL_MOVE;
        else if (stat.scan_last) state_next = pitt_pkg::S_FINISH;
      end
      pitt_pkg::S_DEL_MOVE: begin
        if (stat.out_free) state_next = pitt_pkg::S_IDLE;
      end
      pitt_pkg::S_TICK_SCAN: begin
        if (advance && stat.scan_last) state_next = pitt_pkg::S_TICK_END;
      end
      pitt_pkg::S_TICK_END: begin
        if (stat.out_free) state_next = pitt_pkg::S_IDLE;
      end
      pitt_pkg::S_FINISH: begin
        if (stat.out_free) state_next = pitt_pkg::S_IDLE;
      end
      default: state_next = pitt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.rd_sel    = pitt_pkg::RD_ZERO;
    cmd.wr_sel    = pitt_pkg::WR_NONE;
    cmd.emit      = pitt_pkg::EM_NONE;
    cmd.code      = pitt_pkg::ST_DONE;
    case (state)
      pitt_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      pitt_pkg::S_DECODE: begin
        cmd.start = 1'b1;
      end
      pitt_pkg::S_ADD: begin
        if (stat.out_free) begin
          cmd.emit      = pitt_pkg::EM_CODE;
          cmd.emit_last = 1'b1;
          if (stat.full) begin
            cmd.code = pitt_pkg::ST_FULL;
          end else begin
            cmd.code    = pitt_pkg::ST_DONE;
            cmd.wr_sel  = pitt_pkg::WR_ADD;
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      pitt_pkg::S_DEL_SCAN: begin
        if (stat.match) begin
          cmd.rd_sel = pitt_pkg::RD_TAIL;
        end else if (stat.scan_last) begin
          cmd.rd_sel = pitt_pkg::RD_IDX;
        end else begin
          cmd.rd_sel  = pitt_pkg::RD_NEXT;
          cmd.idx_inc = 1'b1;
        end
      end
      pitt_pkg::S_DEL_MOVE: begin
        cmd.rd_sel = pitt_pkg::RD_TAIL;
        if (stat.out_free) begin
          cmd.wr_sel    = pitt_pkg::WR_MOVE;
          cmd.cnt_dec   = 1'b1;
          cmd.emit      = pitt_pkg::EM_CODE;
          cmd.emit_last = 1'b1;
          cmd.code      = pitt_pkg::ST_DONE;
        end
      end
      pitt_pkg::S_TICK_SCAN: begin
        if (advance) begin
          cmd.wr_sel  = pitt_pkg::WR_TICK;
          cmd.rd_sel  = stat.scan_last ? pitt_pkg::RD_IDX : pitt_pkg::RD_NEXT;
          cmd.idx_inc = !stat.scan_last;
          if (stat.fire) begin
            cmd.pend_load = 1'b1;
            if (stat.pend_valid) cmd.emit = pitt_pkg::EM_PEND;
          end
        end else begin
          cmd.rd_sel = pitt_pkg::RD_IDX;
        end
      end
      pitt_pkg::S_TICK_END: begin
        if (stat.out_free) begin
          cmd.emit_last = 1'b1;
          cmd.code      = pitt_pkg::ST_NONE;
          cmd.emit      = stat.pend_valid ? pitt_pkg::EM_PEND : pitt_pkg::EM_CODE;
        end
      end
      pitt_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit      = pitt_pkg::EM_CODE;
          cmd.emit_last = 1'b1;
          case (stat.op)
            pitt_pkg::OP_DELETE: cmd.code = pitt_pkg::ST_NOT_FOUND;
            pitt_pkg::OP_TICK:   cmd.code = pitt_pkg::ST_NONE;
            default:             cmd.code = pitt_pkg::ST_DONE;
          endcase
        end
      end
      default: begin
        cmd.rd_sel = pitt_pkg::RD_ZERO;
      end
    endcase
  end

endmodule

### hw/rtl/pitt_datapath.sv
// Table memories, counters, configuration registers and result register.
`timescale 1ns / 1ps

module pitt_datapath #(
  parameter int TABLE_ENTRIES = pitt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  pitt_pkg::cmd_t                  cmd,
  output pitt_pkg::stat_t                 stat,
  input  logic [pitt_pkg::OP_W-1:0]       in_operation,
  input  logic [pitt_pkg::LINE_W-1:0]     in_irq_line,
  input  logic [pitt_pkg::IVL_W-1:0]      in_interval,
  input  logic                            cfg_write,
  input  logic [pitt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pitt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pitt_pkg::LINE_W-1:0]     out_line,
  output logic [pitt_pkg::STATUS_W-1:0]   out_status,
  output logic [pitt_pkg::CNT_OUT_W-1:0]  out_count,
  output logic                            out_last
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(TABLE_ENTRIES);

  pitt_pkg::op_t                 op_q;
  logic [pitt_pkg::LINE_W-1:0]   line_q;
  logic [pitt_pkg::IVL_W-1:0]    ivl_q;
  logic [pitt_pkg::PERIOD_W-1:0] poll_period;
  logic                          reload_mode;
  logic [CNT_W-1:0]              count;
  logic [CNT_W-1:0]              count_next;
  logic [IDX_W-1:0]              idx;
  logic                          pend_valid;
  logic [pitt_pkg::LINE_W-1:0]   pend_line;

  logic [pitt_pkg::LINE_W-1:0]   line_mem [TABLE_ENTRIES];
  logic [pitt_pkg::IVL_W-1:0]    ivl_mem  [TABLE_ENTRIES];
  logic [pitt_pkg::IVL_W-1:0]    cd_mem   [TABLE_ENTRIES];
  logic [pitt_pkg::LINE_W-1:0]   line_rd;
  logic [pitt_pkg::IVL_W-1:0]    ivl_rd;
  logic [pitt_pkg::IVL_W-1:0]    cd_rd;

  logic [CNT_W-1:0]              tail;
  logic [IDX_W-1:0]              rd_addr;
  logic [IDX_W-1:0]              wr_addr;
  logic                          wr_entry;
  logic                          wr_cd;
  logic [pitt_pkg::LINE_W-1:0]   line_wr;
  logic [pitt_pkg::IVL_W-1:0]    ivl_wr;
  logic [pitt_pkg::IVL_W-1:0]    cd_wr;
  logic [pitt_pkg::IVL_W-1:0]    cd_tick;
  logic                          fire;

  assign tail = count - CNT_W'(1);
  assign fire = (cd_rd <= pitt_pkg::IVL_W'(1));

  always_comb begin
    case (cmd.rd_sel)
      pitt_pkg::RD_IDX:  rd_addr = idx;
      pitt_pkg::RD_NEXT: rd_addr = idx + IDX_W'(1);
      pitt_pkg::RD_TAIL: rd_addr = tail[IDX_W-1:0];
      default:           rd_addr = '0;
    endcase
  end

  // a firing entry reloads, any other counts down by one
  always_comb begin
    if (fire) begin
      cd_tick = reload_mode ? ivl_rd : poll_period;
    end else begin
      cd_tick = cd_rd - pitt_pkg::IVL_W'(1);
    end
  end

  always_comb begin
    wr_entry = 1'b0;
    wr_cd    = 1'b0;
    wr_addr  = idx;
    line_wr  = line_q;
    ivl_wr   = ivl_q;
    cd_wr    = ivl_q;
    case (cmd.wr_sel)
      pitt_pkg::WR_ADD: begin
        wr_entry = 1'b1;
        wr_cd    = 1'b1;
        wr_addr  = count[IDX_W-1:0];
      end
      pitt_pkg::WR_MOVE: begin
        wr_entry = 1'b1;
        wr_cd    = 1'b1;
        line_wr  = line_rd;
        ivl_wr   = ivl_rd;
        cd_wr    = cd_rd;
      end
      pitt_pkg::WR_TICK: begin
        wr_cd = 1'b1;
        cd_wr = cd_tick;
      end
      default: begin
        wr_cd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_entry) begin
      line_mem[wr_addr] <= line_wr;
      ivl_mem[wr_addr]  <= ivl_wr;
    end
    if (wr_cd) begin
      cd_mem[wr_addr] <= cd_wr;
    end
    line_rd <= line_mem[rd_addr];
    ivl_rd  <= ivl_mem[rd_addr];
    cd_rd   <= cd_mem[rd_addr];
  end

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) count_next = count + CNT_W'(1);
    else if (cmd.cnt_dec) count_next = tail;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q   <= pitt_pkg::op_t'(in_operation);
      line_q <= in_irq_line;
      ivl_q  <= in_interval;
    end
    if (cmd.start) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.pend_load) begin
      pend_line <= line_rd;
    end
    if (cmd.emit != pitt_pkg::EM_NONE) begin
      out_count <= pitt_pkg::CNT_OUT_W'(count_next);
      out_last  <= cmd.emit_last;
      if (cmd.emit == pitt_pkg::EM_PEND) begin
        out_line   <= pend_line;
        out_status <= pitt_pkg::ST_FIRED;
      end else begin
        out_line   <= '0;
        out_status <= cmd.code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
      poll_period <= pitt_pkg::RESET_PERIOD;
      reload_mode <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.start) begin
        pend_valid <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end
      if (cmd.emit != pitt_pkg::EM_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (pitt_pkg::reg_idx_t'(cfg_index))
          pitt_pkg::REG_POLL_PERIOD: poll_period <= cfg_data;
          pitt_pkg::REG_RELOAD_MODE: reload_mode <= cfg_data[0];
          default:                   reload_mode <= reload_mode;
        endcase
      end
    end
  end

  always_comb begin
    stat            = '0;
    stat.op         = op_q;
    stat.empty      = (count == '0);
    stat.full       = (count == CNT_MAX);
    stat.scan_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
    stat.match      = (line_rd == line_q);
    stat.fire       = fire;
    stat.pend_valid = pend_valid;
    stat.out_free   = !out_valid || out_ready;
    stat.disabled   = !reload_mode && (poll_period == '0);
  end

endmodule

### hw/rtl/polled_interrupt_timer_table_core.sv
// Top level of the polled interrupt timer table.
`timescale 1ns / 1ps

// Channel   Dir  Beat contents                               Handshake
// items     in   operation, irq_line, interval               valid/ready
// results   out  fired_line, status, fill_level, last        valid/ready
// cfg       in   index (0 poll_period, 1 reload_mode), data  valid/ready, ready high out of reset
//
// Scans: delete reads the table in order up to the match; tick reads one table entry per
//   cycle, unless its scan stalls, through the single read port of each table memory;
//   a disabled tick or an empty table skips the scan.
// Reset: synchronous rst clears the entry count, the FSM and the result register;
//   table contents are not cleared and are only read below the entry count.
// Stalls: one result register; a new item is taken while the last beat waits.
//   A tick stalls its scan only when a second firing entry finds that register busy.

module polled_interrupt_timer_table_core #(
  parameter int TABLE_ENTRIES = pitt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  pitt_item_if.sink     items,
  pitt_result_if.source results,
  pitt_cfg_if.sink      cfg
);

  pitt_pkg::cmd_t  cmd;
  pitt_pkg::stat_t stat;
  logic            in_ready;

  // configuration writes are register loads; no beat taken in reset
  assign cfg.ready   = !rst;
  assign items.ready = in_ready && !rst;

  pitt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memories, scan index, held firing and result register
  pitt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_operation (items.operation),
    .in_irq_line  (items.irq_line),
    .in_interval  (items.interval),
    .cfg_write    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_line     (results.fired_line),
    .out_status   (results.status),
    .out_count    (results.fill_level),
    .out_last     (results.last)
  );

endmodule

### hw/rtl/pitt_checker.sv
// Port-level assertions of the polled interrupt timer table, bound to the top.
`timescale 1ns / 1ps
`include "polled_interrupt_timer_table_core_assert.svh"

module pitt_checker #(
  parameter int TABLE_ENTRIES = pitt_pkg::TABLE_ENTRIES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           items_valid,
  input logic                           items_ready,
  input logic                           results_valid,
  input logic                           results_ready,
  input logic [pitt_pkg::LINE_W-1:0]    results_fired_line,
  input logic [pitt_pkg::STATUS_W-1:0]  results_status,
  input logic [pitt_pkg::CNT_OUT_W-1:0] results_fill_level,
  input logic                           results_last
);

  localparam logic [pitt_pkg::CNT_OUT_W-1:0] FULL_COUNT =
    pitt_pkg::CNT_OUT_W'(TABLE_ENTRIES);

  logic                                         beat_wait;
  logic [pitt_pkg::LINE_W+pitt_pkg::STATUS_W:0] beat_fields;
  logic                                         fired_beat;
  logic                                         full_beat;

  assign beat_wait   = results_valid && !results_ready;
  assign beat_fields = {results_fired_line, results_status, results_last};
  assign fired_beat  = (results_status == pitt_pkg::ST_FIRED);
  assign full_beat   = (results_status == pitt_pkg::ST_FULL);

  // a waiting result beat holds
  `PITT_ASSERT_NEXT(a_result_hold, beat_wait, results_valid && $stable(beat_fields))

  // only firing beats can be followed by more beats of the same item
  `PITT_ASSERT_IMP(a_last_on_single, results_valid && !fired_beat, results_last)

  // a full report means the table really is at capacity
  `PITT_ASSERT_IMP(a_full_count, results_valid && full_beat, results_fill_level == FULL_COUNT)

  // one item at a time: input closes right after an accept
  `PITT_ASSERT_NEXT(a_one_item, items_valid && items_ready, !items_ready)

endmodule

bind polled_interrupt_timer_table_core pitt_checker #(
  .TABLE_ENTRIES (TABLE_ENTRIES)
) u_pitt_checker (
  .clk                (clk),
  .rst                (rst),
  .items_valid        (items.valid),
  .items_ready        (items.ready),
  .results_valid      (results.valid),
  .results_ready      (results.ready),
  .results_fired_line (results.fired_line),
  .results_status     (results.status),
  .results_fill_level (results.fill_level),
  .results_last       (results.last)
);
